>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising edge, off while reset is held.
`define ASSERT_CLK_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check on every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> design/ipc_pkg.sv
// ----------------------------------------------------------------------------
// ipc_pkg
// Types and constants of the irrigation pump controller.
// ----------------------------------------------------------------------------
package ipc_pkg;

    localparam int unsigned MoistW = 10;
    localparam int unsigned CntW   = 8;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 10;

    localparam logic [CntW-1:0] CntMax = 8'hFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_MOISTURE_LOW     = 3'd0,
        CFG_MOISTURE_HIGH    = 3'd1,
        CFG_AUTO_MAX_SECONDS = 3'd2,
        CFG_MANUAL_SECONDS   = 3'd3,
        CFG_SAMPLE_INTERVAL  = 3'd4
    } t_cfg_idx;

    localparam logic [MoistW-1:0] MoistureLowRst  = 10'd300;
    localparam logic [MoistW-1:0] MoistureHighRst = 10'd800;
    localparam logic [CntW-1:0]   AutoMaxRst      = 8'd5;
    localparam logic [CntW-1:0]   ManualSecRst    = 8'd5;
    localparam logic [CntW-1:0]   SampleIntRst    = 8'd1;

    typedef struct packed {
        logic              mode_button;
        logic              water_button;
        logic [MoistW-1:0] soil_moisture;
    } t_tick;

    typedef struct packed {
        logic pump_on;
        logic water_led;
        logic manual_mode;
    } t_result;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        logic [CntW-1:0] r;
        r = (v == CntMax) ? CntMax : v + 1'b1;
        return r;
    endfunction

endpackage

>>> design/ipc_tick_if.sv
// ----------------------------------------------------------------------------
// ipc_tick_if
// Valid/ready channel carrying one tick item.
// ----------------------------------------------------------------------------
interface ipc_tick_if;
    logic           valid;
    logic           ready;
    ipc_pkg::t_tick data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/ipc_result_if.sv
// ----------------------------------------------------------------------------
// ipc_result_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface ipc_result_if;
    logic             valid;
    logic             ready;
    ipc_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> design/irrigation_pump_controller_top.sv
// ----------------------------------------------------------------------------
// irrigation_pump_controller_top
// Moisture hysteresis pump control with auto/manual mode and timed watering.
// ----------------------------------------------------------------------------
//  channel    dir  payload                                      handshake
//  i_item     in   mode_button, water_button, soil_moisture     valid/ready
//  o_result   out  pump_on, water_led, manual_mode              valid/ready
//  cfg        in   i_cfg_we, i_cfg_idx, i_cfg_data              write only
//
//  One item per cycle while o_result is not stalled; its result is valid the cycle after acceptance.
//  The state update and the result register load in the accepting cycle.
//  Synchronous active-low reset restores the register defaults, auto mode,
//  pump off and both counters at zero.
//  i_item.ready is high while the result register is empty or being taken.
// ----------------------------------------------------------------------------
module irrigation_pump_controller_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    ipc_tick_if.sink                         i_item,
    ipc_result_if.source                     o_result,
    input  logic                             i_cfg_we,
    input  logic [ipc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [ipc_pkg::CfgDataW-1:0]     i_cfg_data
);

    logic [ipc_pkg::MoistW-1:0] r_moist_low;
    logic [ipc_pkg::MoistW-1:0] r_moist_high;
    logic [ipc_pkg::CntW-1:0]   r_auto_max;
    logic [ipc_pkg::CntW-1:0]   r_manual_sec;
    logic [ipc_pkg::CntW-1:0]   r_sample_int;

    logic                       r_manual;
    logic                       r_pump;
    logic [ipc_pkg::CntW-1:0]   r_water_cnt;
    logic [ipc_pkg::CntW-1:0]   r_sample_cnt;

    logic                       n_manual;
    logic                       n_pump;
    logic [ipc_pkg::CntW-1:0]   n_water_cnt;
    logic [ipc_pkg::CntW-1:0]   n_sample_cnt;

    logic                       r_out_valid;
    ipc_pkg::t_result           r_out_data;

    logic                       accept;

    assign i_item.ready    = !r_out_valid || o_result.ready;
    assign accept          = i_item.valid && i_item.ready;
    assign o_result.valid  = r_out_valid;
    assign o_result.data   = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moist_low  <= ipc_pkg::MoistureLowRst;
            r_moist_high <= ipc_pkg::MoistureHighRst;
            r_auto_max   <= ipc_pkg::AutoMaxRst;
            r_manual_sec <= ipc_pkg::ManualSecRst;
            r_sample_int <= ipc_pkg::SampleIntRst;
        end else if (i_cfg_we) begin
            unique case (ipc_pkg::t_cfg_idx'(i_cfg_idx))
                ipc_pkg::CFG_MOISTURE_LOW:     r_moist_low  <= i_cfg_data;
                ipc_pkg::CFG_MOISTURE_HIGH:    r_moist_high <= i_cfg_data;
                ipc_pkg::CFG_AUTO_MAX_SECONDS:
                    r_auto_max   <= i_cfg_data[ipc_pkg::CntW-1:0];
                ipc_pkg::CFG_MANUAL_SECONDS:
                    r_manual_sec <= i_cfg_data[ipc_pkg::CntW-1:0];
                ipc_pkg::CFG_SAMPLE_INTERVAL:
                    r_sample_int <= i_cfg_data[ipc_pkg::CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        logic                     pump;
        logic [ipc_pkg::CntW-1:0] wcnt;
        logic [ipc_pkg::CntW-1:0] scnt;
        logic                     mode;

        scnt = ipc_pkg::sat_inc(r_sample_cnt);
        mode = r_manual ^ i_item.data.mode_button;
        pump = r_pump && !(i_item.data.mode_button && !r_manual);
        wcnt = r_water_cnt;

        if (!mode) begin
            if (scnt >= r_sample_int) begin
                scnt = '0;
                if (!pump) begin
                    if (i_item.data.soil_moisture < r_moist_low) begin
                        pump = 1'b1;
                        wcnt = '0;
                    end
                end else if (i_item.data.soil_moisture > r_moist_high) begin
                    pump = 1'b0;
                end
            end
            if (pump) begin
                wcnt = ipc_pkg::sat_inc(wcnt);
                if (wcnt > r_auto_max) begin
                    pump = 1'b0;
                end
            end
        end else begin
            if (i_item.data.water_button && !pump) begin
                pump = 1'b1;
                wcnt = '0;
            end
            if (pump) begin
                wcnt = ipc_pkg::sat_inc(wcnt);
                if (wcnt >= r_manual_sec) begin
                    pump = 1'b0;
                end
            end
        end

        n_manual     = mode;
        n_pump       = pump;
        n_water_cnt  = wcnt;
        n_sample_cnt = scnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual     <= 1'b0;
            r_pump       <= 1'b0;
            r_water_cnt  <= '0;
            r_sample_cnt <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_manual     <= n_manual;
                r_pump       <= n_pump;
                r_water_cnt  <= n_water_cnt;
                r_sample_cnt <= n_sample_cnt;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data.pump_on     <= n_pump;
            r_out_data.water_led   <= n_pump;
            r_out_data.manual_mode <= n_manual;
        end
    end

endmodule

>>> design/ipc_checker.sv
// ----------------------------------------------------------------------------
// ipc_checker
// Port-level checks of the irrigation pump controller, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ipc_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_pump_on,
    input logic i_out_water_led,
    input logic i_out_manual_mode
);

    logic       out_stall;
    logic [2:0] out_bits;

    assign out_stall = i_out_valid && !i_out_ready;
    assign out_bits  = {i_out_pump_on, i_out_water_led, i_out_manual_mode};

    `ASSERT_CLK_RST(a_stall_hold, i_clk, i_rst_n, out_stall |=> i_out_valid && $stable(out_bits))

    `ASSERT_CLK_RST(a_led_pump, i_clk, i_rst_n, i_out_valid |-> i_out_water_led == i_out_pump_on)

    `ASSERT_CLK_RST(a_accept_result, i_clk, i_rst_n, i_in_valid && i_in_ready |=> i_out_valid)

    `ASSERT_CLK(a_empty_means_ready, i_clk, !i_out_valid |-> i_in_ready)

    `ASSERT_CLK(a_reset_clears_valid, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind irrigation_pump_controller_top ipc_checker u_ipc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_item.valid),
    .i_in_ready         (i_item.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_out_pump_on      (o_result.data.pump_on),
    .i_out_water_led    (o_result.data.water_led),
    .i_out_manual_mode  (o_result.data.manual_mode)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the irrigation pump controller tick by tick against a predicted pump
// and mode state: a directed run through the threshold, timeout and button
// cases, then random phases under changing register settings with bursty
// ticks, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned PeriodNs    = 4;
    localparam int unsigned CycleLimit  = 300000;
    localparam int unsigned NumPhases   = 10;
    localparam int unsigned PhaseItems  = 75;
    localparam int unsigned LongHold    = 64;
    localparam int unsigned DrainLimit  = 500;
    localparam int unsigned MaxReports  = 60;
    localparam logic [ipc_pkg::CfgIdxW-1:0] CfgSpareIdx = 3'd7;

    typedef enum int {RX_ALWAYS = 0, RX_RANDOM = 1, RX_PATTERN = 2} t_rx_style;

    class pump_expectations;
        logic [ipc_pkg::MoistW-1:0] low_thr;
        logic [ipc_pkg::MoistW-1:0] high_thr;
        logic [ipc_pkg::CntW-1:0]   auto_limit;
        logic [ipc_pkg::CntW-1:0]   manual_limit;
        logic [ipc_pkg::CntW-1:0]   interval;
        logic                       in_manual;
        logic                       pump;
        logic [ipc_pkg::CntW-1:0]   water_cnt;
        logic [ipc_pkg::CntW-1:0]   sample_cnt;
        ipc_pkg::t_result           expected_outputs[$];
        int                         errors;
        int                         reports;
        int                         n_ticks;
        int                         n_pump_on;
        int                         n_manual;

        function new();
            low_thr      = ipc_pkg::MoistureLowRst;
            high_thr     = ipc_pkg::MoistureHighRst;
            auto_limit   = ipc_pkg::AutoMaxRst;
            manual_limit = ipc_pkg::ManualSecRst;
            interval     = ipc_pkg::SampleIntRst;
            in_manual    = 1'b0;
            pump         = 1'b0;
            water_cnt    = '0;
            sample_cnt   = '0;
            errors       = 0;
            reports      = 0;
            n_ticks      = 0;
            n_pump_on    = 0;
            n_manual     = 0;
        endfunction

        function logic [ipc_pkg::CntW-1:0] bump(input logic [ipc_pkg::CntW-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void set_reg(input logic [ipc_pkg::CfgIdxW-1:0] idx,
                              input logic [ipc_pkg::CfgDataW-1:0] val);
            case (idx)
                ipc_pkg::CFG_MOISTURE_LOW:     low_thr      = val;
                ipc_pkg::CFG_MOISTURE_HIGH:    high_thr     = val;
                ipc_pkg::CFG_AUTO_MAX_SECONDS: auto_limit   = val[ipc_pkg::CntW-1:0];
                ipc_pkg::CFG_MANUAL_SECONDS:   manual_limit = val[ipc_pkg::CntW-1:0];
                ipc_pkg::CFG_SAMPLE_INTERVAL:  interval     = val[ipc_pkg::CntW-1:0];
                default: ;
            endcase
        endfunction

        function void note_tick(input ipc_pkg::t_tick t);
            ipc_pkg::t_result r;
            sample_cnt = bump(sample_cnt);
            if (t.mode_button) begin
                if (!in_manual) begin
                    in_manual = 1'b1;
                    pump      = 1'b0;
                end else begin
                    in_manual = 1'b0;
                end
            end
            if (!in_manual) begin
                if (sample_cnt >= interval) begin
                    sample_cnt = '0;
                    if (!pump) begin
                        if (t.soil_moisture < low_thr) begin
                            pump      = 1'b1;
                            water_cnt = '0;
                        end
                    end else if (t.soil_moisture > high_thr) begin
                        pump = 1'b0;
                    end
                end
                if (pump) begin
                    water_cnt = bump(water_cnt);
                    if (water_cnt > auto_limit) pump = 1'b0;
                end
            end else begin
                if (t.water_button && !pump) begin
                    pump      = 1'b1;
                    water_cnt = '0;
                end
                if (pump) begin
                    water_cnt = bump(water_cnt);
                    if (water_cnt >= manual_limit) pump = 1'b0;
                end
            end
            r.pump_on     = pump;
            r.water_led   = pump;
            r.manual_mode = in_manual;
            expected_outputs.push_back(r);
            n_ticks++;
            if (pump) n_pump_on++;
            if (in_manual) n_manual++;
        endfunction

        function void report(input string what, input logic want, input logic got);
            errors++;
            if (reports < MaxReports) begin
                reports++;
                $display("%0t: %s mismatch: expected %0b actual %0b", $time, what, want, got);
            end
        endfunction

        function void check_result(input ipc_pkg::t_result got);
            ipc_pkg::t_result want;
            if (expected_outputs.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected: actual %b", $time, got);
                return;
            end
            want = expected_outputs.pop_front();
            if (got.pump_on !== want.pump_on)
                report("pump_on", want.pump_on, got.pump_on);
            if (got.water_led !== want.water_led)
                report("water_led", want.water_led, got.water_led);
            if (got.manual_mode !== want.manual_mode)
                report("manual_mode", want.manual_mode, got.manual_mode);
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_we;
    logic [ipc_pkg::CfgIdxW-1:0]  i_cfg_idx;
    logic [ipc_pkg::CfgDataW-1:0] i_cfg_data;

    ipc_tick_if   tick_ch ();
    ipc_result_if res_ch ();

    pump_expectations sb;
    t_rx_style        rx_style;
    logic [7:0]       rx_pattern;
    logic             hold_req;
    int               moist_cls;
    int               cycle_cnt;

    irrigation_pump_controller_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (tick_ch),
        .o_result   (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(PeriodNs / 2) i_clk = ~i_clk;
    end

    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CycleLimit) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && tick_ch.valid && tick_ch.ready) sb.note_tick(tick_ch.data);
        if (i_rst_n && res_ch.valid && res_ch.ready) sb.check_result(res_ch.data);
    end

    // receiver: per-phase stall style, plus one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = LongHold - 1;
                res_ch.ready <= 1'b0;
            end else begin
                case (rx_style)
                    RX_ALWAYS: res_ch.ready <= 1'b1;
                    RX_RANDOM: res_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: begin
                        res_ch.ready <= rx_pattern[0];
                        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic ipc_pkg::t_tick mk(input logic m, input logic w, input int unsigned s);
        ipc_pkg::t_tick t;
        t.mode_button   = m;
        t.water_button  = w;
        t.soil_moisture = s[ipc_pkg::MoistW-1:0];
        return t;
    endfunction

    function automatic ipc_pkg::t_tick next_tick();
        ipc_pkg::t_tick t;
        int             off;
        int             v;
        if ($urandom_range(0, 5) == 0) moist_cls = $urandom_range(0, 4);
        off = int'($urandom_range(0, 4)) - 2;
        case (moist_cls)
            0: v = $urandom_range(0, 1023);
            1: v = int'(sb.low_thr) + off;
            2: v = int'(sb.high_thr) + off;
            3: v = $urandom_range(0, 15);
            default: v = $urandom_range(990, 1023);
        endcase
        t.mode_button   = ($urandom_range(0, 15) == 0);
        t.water_button  = ($urandom_range(0, 2) == 0);
        t.soil_moisture = (v < 0) ? '0 : (v > 1023) ? '1 : v[ipc_pkg::MoistW-1:0];
        return t;
    endfunction

    task automatic send_tick(input ipc_pkg::t_tick t);
        tick_ch.valid <= 1'b1;
        tick_ch.data  <= t;
        do @(posedge i_clk); while (!tick_ch.ready);
    endtask

    task automatic write_reg(input logic [ipc_pkg::CfgIdxW-1:0] idx,
                             input logic [ipc_pkg::CfgDataW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    task automatic program_settings(input int unsigned lo, input int unsigned hi,
                                    input int unsigned amax, input int unsigned msec,
                                    input int unsigned intv, input bit poke_spare);
        write_reg(ipc_pkg::CFG_MOISTURE_LOW, lo[ipc_pkg::CfgDataW-1:0]);
        write_reg(ipc_pkg::CFG_MOISTURE_HIGH, hi[ipc_pkg::CfgDataW-1:0]);
        write_reg(ipc_pkg::CFG_AUTO_MAX_SECONDS, amax[ipc_pkg::CfgDataW-1:0]);
        write_reg(ipc_pkg::CFG_MANUAL_SECONDS, msec[ipc_pkg::CfgDataW-1:0]);
        write_reg(ipc_pkg::CFG_SAMPLE_INTERVAL, intv[ipc_pkg::CfgDataW-1:0]);
        if (poke_spare) write_reg(CfgSpareIdx, '1);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic run_phase(input int unsigned n_items, input bit no_gaps);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            for (int unsigned k = 0; k < burst && sent < n_items; k++) begin
                send_tick(next_tick());
                sent++;
            end
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (gap > 0) begin
                tick_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tick_ch.valid <= 1'b0;
    endtask

    initial begin
        ipc_pkg::t_tick directed[$];
        int unsigned    lo;
        int unsigned    drain;
        sb         = new();
        rx_style   = RX_RANDOM;
        rx_pattern = 8'b1011_0110;
        hold_req   = 1'b0;
        moist_cls  = 0;
        tick_ch.valid <= 1'b0;
        tick_ch.data  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        i_rst_n       <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: low 300, high 800, timeouts 5, interval 1
        directed = '{mk(1'b0, 1'b0, 500), mk(1'b0, 1'b0, 0), mk(1'b0, 1'b0, 299),
                     mk(1'b0, 1'b0, 299), mk(1'b0, 1'b0, 299), mk(1'b0, 1'b0, 299),
                     mk(1'b0, 1'b0, 300), mk(1'b0, 1'b0, 300), mk(1'b0, 1'b0, 10),
                     mk(1'b0, 1'b0, 800), mk(1'b0, 1'b0, 801), mk(1'b0, 1'b0, 1023),
                     mk(1'b0, 1'b0, 1000), mk(1'b0, 1'b1, 0), mk(1'b1, 1'b0, 0),
                     mk(1'b0, 1'b1, 1023), mk(1'b0, 1'b1, 0), mk(1'b1, 1'b1, 512),
                     mk(1'b1, 1'b1, 0), mk(1'b0, 1'b0, 0), mk(1'b0, 1'b0, 0),
                     mk(1'b0, 1'b0, 0), mk(1'b0, 1'b0, 0), mk(1'b1, 1'b0, 700)};
        foreach (directed[k]) send_tick(directed[k]);
        tick_ch.valid <= 1'b0;
        wait_idle();

        for (int ph = 0; ph < NumPhases; ph++) begin
            case (ph)
                0: program_settings(0, 0, 0, 0, 0, 1'b0);
                1: program_settings(1000, 1000, 255, 255, 255, 1'b0);
                2: program_settings(800, 300, 3, 1, 0, 1'b1);
                default: begin
                    lo = $urandom_range(0, 1000);
                    program_settings(lo, $urandom_range(lo, 1000), $urandom_range(0, 10),
                                     $urandom_range(0, 10), $urandom_range(0, 4), 1'b0);
                end
            endcase
            rx_style   = t_rx_style'(ph % 3);
            rx_pattern = 8'($urandom_range(1, 255));
            if (ph == 4) hold_req = 1'b1;
            run_phase(PhaseItems, (ph % 4) == 1);
            wait_idle();
        end

        drain = 0;
        while (sb.pending() != 0 && drain < DrainLimit) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (4) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.errors += sb.pending();
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
        end

        $display("covered %0d ticks over %0d register settings plus reset defaults",
                 sb.n_ticks, NumPhases);
        $display("pump on in %0d results, manual mode in %0d results, %0d mismatches",
                 sb.n_pump_on, sb.n_manual, sb.errors);
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/ipc_pkg.sv
design/ipc_tick_if.sv
design/ipc_result_if.sv
design/irrigation_pump_controller_top.sv
design/ipc_checker.sv
bench/testbench.sv
